>>> rtl/ctweb_pkg.sv
// package for the completion tracker with early buffer
// holds command, action and register codes plus the early store entry type; no dependencies
package ctweb_pkg;

  // field widths fixed by the interface
  localparam int unsigned IdW      = 32;
  localparam int unsigned StatusW  = 8;
  localparam int unsigned DiagW    = 32;
  localparam int unsigned CountW   = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned MaxPendW = 5;

  // reset value of max_pending
  localparam logic [MaxPendW-1:0] MaxPendReset = 5'd16;

  // input commands; the fourth code is ignored
  typedef enum logic [1:0] {
    CmdTrack    = 2'd0,
    CmdComplete = 2'd1,
    CmdClear    = 2'd2
  } command_e;

  // result actions
  typedef enum logic [3:0] {
    ActRejected     = 4'd0,
    ActPending      = 4'd1,
    ActConsumedOk   = 4'd2,
    ActConsumedFail = 4'd3,
    ActStale        = 4'd4,
    ActUnknown      = 4'd5,
    ActAcceptedOk   = 4'd6,
    ActAcceptedFail = 4'd7,
    ActCleared      = 4'd8
  } action_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSession    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGeneration = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxPending = 2'd2;

  // one early completion
  typedef struct packed {
    logic [IdW-1:0]     key;
    logic [StatusW-1:0] status;
    logic               fail;
    logic [DiagW-1:0]   diag;
  } early_ent_t;

endpackage

>>> rtl/completion_tracker_with_early_buffer.sv
// top level of the completion tracker with early buffer
// depends on ctweb_pkg for codes and the early store entry type
//
// Tracks outstanding requests by id and parks completions that arrive before their track
// command. One word is accepted per clock while the output register is free or being read.
// A word moves from the input register into the output register at the first edge where the
// output register is free, so its result passes through the input register and then the
// output register. The rate is set by the update of the pending set (parallel match over
// PENDING_DEPTH entries) and the early store (parallel match and shift over EARLY_DEPTH
// entries). The configuration port is always ready; writing the session or generation
// register empties both stores in that cycle.
module completion_tracker_with_early_buffer #(
  parameter int unsigned PENDING_DEPTH = 16,
  parameter int unsigned EARLY_DEPTH   = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ctweb_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic [ctweb_pkg::IdW-1:0]         session_id_i,
  input  logic [ctweb_pkg::IdW-1:0]         generation_i,
  input  logic [ctweb_pkg::IdW-1:0]         present_id_i,
  input  logic [ctweb_pkg::StatusW-1:0]     status_code_i,
  input  logic                              status_failed_i,
  input  logic [ctweb_pkg::DiagW-1:0]       diag_tag_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [3:0]                        action_o,
  output logic [ctweb_pkg::StatusW-1:0]     completion_status_o,
  output logic [ctweb_pkg::DiagW-1:0]       diag_out_o,
  output logic [ctweb_pkg::CountW-1:0]      pending_count_o
);

  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned EW = $clog2(EARLY_DEPTH + 1);

  // configuration registers
  logic [ctweb_pkg::IdW-1:0]      sess_q, gen_q;
  logic [ctweb_pkg::MaxPendW-1:0] max_pend_q;
  logic                           cfg_clr;

  // input register
  logic                           s1_valid_q;
  logic [1:0]                     s1_cmd_q;
  logic [ctweb_pkg::IdW-1:0]      s1_sess_q, s1_gen_q, s1_id_q;
  logic [ctweb_pkg::StatusW-1:0]  s1_status_q;
  logic                           s1_fail_q;
  logic [ctweb_pkg::DiagW-1:0]    s1_diag_q;

  // output register
  logic                           out_valid_q;
  logic [3:0]                     act_q;
  logic [ctweb_pkg::StatusW-1:0]  st_q;
  logic [ctweb_pkg::DiagW-1:0]    dg_q;
  logic [ctweb_pkg::CountW-1:0]   cnt_out_q;

  // pending set
  logic [PENDING_DEPTH-1:0]       pv_q, pv_d;
  logic [ctweb_pkg::IdW-1:0]      pk_q [PENDING_DEPTH];
  logic [CW-1:0]                  cnt_q, cnt_d;

  // early store, oldest at entry zero
  ctweb_pkg::early_ent_t          ent_q [EARLY_DEPTH];
  ctweb_pkg::early_ent_t          ent_d [EARLY_DEPTH];
  logic [EW-1:0]                  fill_q, fill_d;

  // step logic
  logic                           adv;
  logic                           cur;
  logic [PENDING_DEPTH-1:0]       pend_hit, free_first;
  logic                           any_pend;
  logic [EARLY_DEPTH-1:0]         early_hit, early_first;
  logic                           any_early;
  ctweb_pkg::early_ent_t          hit_ent, new_ent;
  logic                           room, early_full;
  logic                           ins, app, rm_en;
  logic [EARLY_DEPTH-1:0]         rm_first, shm;
  logic [EW-1:0]                  wr_pos;
  ctweb_pkg::action_e             act;
  logic [ctweb_pkg::StatusW-1:0]  st;
  logic [ctweb_pkg::DiagW-1:0]    dg;
  logic [CW+ctweb_pkg::CountW-1:0] cnt_ext;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign adv         = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || adv;
  assign cfg_clr     = cfg_valid_i &&
                       (cfg_index_i == ctweb_pkg::RegSession ||
                        cfg_index_i == ctweb_pkg::RegGeneration);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_q     <= '0;
      gen_q      <= '0;
      max_pend_q <= ctweb_pkg::MaxPendReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ctweb_pkg::RegSession:    sess_q <= cfg_data_i;
        ctweb_pkg::RegGeneration: gen_q  <= cfg_data_i;
        ctweb_pkg::RegMaxPending: begin
          if (cfg_data_i[ctweb_pkg::MaxPendW-1:0] == '0) begin
            max_pend_q <= ctweb_pkg::MaxPendW'(1);
          end else begin
            max_pend_q <= cfg_data_i[ctweb_pkg::MaxPendW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_cmd_q    <= command_i;
      s1_sess_q   <= session_id_i;
      s1_gen_q    <= generation_i;
      s1_id_q     <= present_id_i;
      s1_status_q <= status_code_i;
      s1_fail_q   <= status_failed_i;
      s1_diag_q   <= diag_tag_i;
    end
  end

  // parallel matches
  assign cur = (s1_sess_q == sess_q) && (s1_gen_q == gen_q);

  always_comb begin
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      pend_hit[i] = pv_q[i] && (pk_q[i] == s1_id_q);
    end
    for (int j = 0; j < EARLY_DEPTH; j++) begin
      early_hit[j] = (EW'(j) < fill_q) && (ent_q[j].key == s1_id_q);
    end
  end

  assign any_pend    = |pend_hit;
  assign any_early   = |early_hit;
  assign early_first = early_hit & (~early_hit + EARLY_DEPTH'(1));
  assign free_first  = ~pv_q & (pv_q + PENDING_DEPTH'(1));
  assign room        = (cnt_q < CW'(PENDING_DEPTH)) &&
                       ({{ctweb_pkg::MaxPendW{1'b0}}, cnt_q} <
                        {{CW{1'b0}}, max_pend_q});
  assign early_full  = (fill_q == EW'(EARLY_DEPTH));

  // fields of the oldest matching early entry
  always_comb begin
    hit_ent = '0;
    for (int j = 0; j < EARLY_DEPTH; j++) begin
      if (early_first[j]) begin
        hit_ent = hit_ent | ent_q[j];
      end
    end
  end

  assign new_ent = '{key: s1_id_q, status: s1_status_q, fail: s1_fail_q, diag: s1_diag_q};

  // command decision
  always_comb begin
    act      = ctweb_pkg::ActRejected;
    st       = '0;
    dg       = '0;
    pv_d     = pv_q;
    cnt_d    = cnt_q;
    fill_d   = fill_q;
    ins      = 1'b0;
    app      = 1'b0;
    rm_en    = 1'b0;
    rm_first = '0;
    case (s1_cmd_q)
      ctweb_pkg::CmdTrack: begin
        if (cur && s1_id_q != '0 && !any_pend) begin
          if (any_early) begin
            act      = hit_ent.fail ? ctweb_pkg::ActConsumedFail : ctweb_pkg::ActConsumedOk;
            st       = hit_ent.status;
            dg       = hit_ent.diag;
            rm_en    = 1'b1;
            rm_first = early_first;
            fill_d   = fill_q - EW'(1);
          end else if (room) begin
            act   = ctweb_pkg::ActPending;
            ins   = 1'b1;
            pv_d  = pv_q | free_first;
            cnt_d = cnt_q + CW'(1);
          end
        end
      end
      ctweb_pkg::CmdComplete: begin
        if (!cur) begin
          act = ctweb_pkg::ActStale;
        end else if (!any_pend) begin
          act = ctweb_pkg::ActUnknown;
          if (s1_id_q != '0) begin
            app = 1'b1;
            if (early_full) begin
              // drop the oldest entry to make room
              rm_en    = 1'b1;
              rm_first = EARLY_DEPTH'(1);
            end else begin
              fill_d = fill_q + EW'(1);
            end
          end
        end else begin
          act   = s1_fail_q ? ctweb_pkg::ActAcceptedFail : ctweb_pkg::ActAcceptedOk;
          pv_d  = pv_q & ~pend_hit;
          cnt_d = cnt_q - CW'(1);
        end
      end
      ctweb_pkg::CmdClear: begin
        act    = ctweb_pkg::ActCleared;
        pv_d   = '0;
        cnt_d  = '0;
        fill_d = '0;
      end
      default: ;
    endcase
  end

  // entries at and above the removed one move down by one
  assign shm    = rm_en ? ~(rm_first - EARLY_DEPTH'(1)) : '0;
  assign wr_pos = early_full ? EW'(EARLY_DEPTH - 1) : fill_q;

  // next early store contents
  for (genvar j = 0; j < EARLY_DEPTH; j++) begin : g_early
    ctweb_pkg::early_ent_t moved;
    if (j < EARLY_DEPTH - 1) begin : g_shift
      assign moved = shm[j] ? ent_q[j+1] : ent_q[j];
    end else begin : g_last
      assign moved = ent_q[j];
    end
    assign ent_d[j] = (app && EW'(j) == wr_pos) ? new_ent : moved;
  end

  // store control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= '0;
      cnt_q  <= '0;
      fill_q <= '0;
    end else if (cfg_clr) begin
      pv_q   <= '0;
      cnt_q  <= '0;
      fill_q <= '0;
    end else if (adv) begin
      pv_q   <= pv_d;
      cnt_q  <= cnt_d;
      fill_q <= fill_d;
    end
  end

  // pending keys and early entries
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < PENDING_DEPTH; i++) begin
        if (ins && free_first[i]) begin
          pk_q[i] <= s1_id_q;
        end
      end
      for (int j = 0; j < EARLY_DEPTH; j++) begin
        ent_q[j] <= ent_d[j];
      end
    end
  end

  // output register
  assign cnt_ext = {{ctweb_pkg::CountW{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      act_q     <= act;
      st_q      <= st;
      dg_q      <= dg;
      cnt_out_q <= cnt_ext[ctweb_pkg::CountW-1:0];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign action_o            = act_q;
  assign completion_status_o = st_q;
  assign diag_out_o          = dg_q;
  assign pending_count_o     = cnt_out_q;

endmodule

>>> rtl/ctweb_checker.sv
// port-level checks for the completion tracker with early buffer
// depends on ctweb_pkg for action codes; bound to the top level below
module ctweb_checker #(
  parameter int unsigned PENDING_DEPTH = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [3:0]                    action_o,
  input logic [ctweb_pkg::StatusW-1:0] completion_status_o,
  input logic [ctweb_pkg::DiagW-1:0]   diag_out_o,
  input logic [ctweb_pkg::CountW-1:0]  pending_count_o
);

  // a stalled result word holds its action and pending count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o) &&
    $stable(pending_count_o))
    else $error("result word changed while stalled");

  // pending count never exceeds the pending set size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && PENDING_DEPTH < 32 |-> 32'(pending_count_o) <= PENDING_DEPTH)
    else $error("pending count above pending set size");

  // a clear leaves nothing pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ctweb_pkg::ActCleared |-> pending_count_o == '0)
    else $error("pending entries left after clear");

  // status and diagnostic words only come with a consumed early completion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (completion_status_o != '0 || diag_out_o != '0) |->
    (action_o == ctweb_pkg::ActConsumedOk || action_o == ctweb_pkg::ActConsumedFail))
    else $error("status or diag word without a consumed completion");

  // action stays inside the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> action_o <= ctweb_pkg::ActCleared)
    else $error("undefined action code");

endmodule

bind completion_tracker_with_early_buffer ctweb_checker #(
  .PENDING_DEPTH(PENDING_DEPTH)
) u_ctweb_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .action_o            (action_o),
  .completion_status_o (completion_status_o),
  .diag_out_o          (diag_out_o),
  .pending_count_o     (pending_count_o)
);

>>> tb/completion_tracker_with_early_buffer_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for completion_tracker_with_early_buffer
// depends on ctweb_pkg and the tracker rtl; mirrors pending set and early store to check results

module completion_tracker_with_early_buffer_tb;

  localparam int unsigned PendDepth     = 16;
  localparam int unsigned EarlyDepth    = 8;
  localparam logic [1:0]  CmdUnused     = 2'd3;
  localparam logic [ctweb_pkg::CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int unsigned MaxWait       = 18;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned PhaseWords    = 50;
  localparam int unsigned NumPhases     = 8;

  typedef struct packed {
    logic [1:0]                    command;
    logic [ctweb_pkg::IdW-1:0]     session;
    logic [ctweb_pkg::IdW-1:0]     generation;
    logic [ctweb_pkg::IdW-1:0]     present_id;
    logic [ctweb_pkg::StatusW-1:0] status_code;
    logic                          status_failed;
    logic [ctweb_pkg::DiagW-1:0]   diag_tag;
  } request_t;

  typedef struct packed {
    ctweb_pkg::action_e            action;
    logic [ctweb_pkg::StatusW-1:0] status;
    logic [ctweb_pkg::DiagW-1:0]   diag;
    logic [ctweb_pkg::CountW-1:0]  count;
  } outcome_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [ctweb_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [1:0] command_i;
  logic [ctweb_pkg::IdW-1:0] session_id_i;
  logic [ctweb_pkg::IdW-1:0] generation_i;
  logic [ctweb_pkg::IdW-1:0] present_id_i;
  logic [ctweb_pkg::StatusW-1:0] status_code_i;
  logic status_failed_i;
  logic [ctweb_pkg::DiagW-1:0] diag_tag_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [3:0] action_o;
  logic [ctweb_pkg::StatusW-1:0] completion_status_o;
  logic [ctweb_pkg::DiagW-1:0] diag_out_o;
  logic [ctweb_pkg::CountW-1:0] pending_count_o;

  completion_tracker_with_early_buffer DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .command_i           (command_i),
    .session_id_i        (session_id_i),
    .generation_i        (generation_i),
    .present_id_i        (present_id_i),
    .status_code_i       (status_code_i),
    .status_failed_i     (status_failed_i),
    .diag_tag_i          (diag_tag_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .action_o            (action_o),
    .completion_status_o (completion_status_o),
    .diag_out_o          (diag_out_o),
    .pending_count_o     (pending_count_o)
  );

  // mirror of the tracker registers and stores
  logic [31:0]                cur_session;
  logic [31:0]                cur_generation;
  logic [4:0]                 pend_limit;
  bit                         pend_valid [PendDepth];
  logic [ctweb_pkg::IdW-1:0]  pend_key [PendDepth];
  ctweb_pkg::early_ent_t      early_store [$];

  request_t request_backlog [$];
  outcome_t outcomes_due [$];
  int words_queued;
  int results_seen;
  int mismatches;

  // handshake flags seen at the last rising edge
  logic in_accepted;
  logic out_accepted;
  logic cfg_accepted;

  bit send_quiet;
  bit recv_quiet;
  int unsigned send_wait;
  int unsigned recv_wait;
  int stall_asks;
  int stall_seen;
  int unsigned stall_left;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned draw_wait(bit quiet);
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MaxWait);
  endfunction

  function automatic void empty_stores();
    foreach (pend_valid[i]) pend_valid[i] = 1'b0;
    early_store.delete();
  endfunction

  function automatic int find_pending(logic [ctweb_pkg::IdW-1:0] id);
    for (int i = 0; i < PendDepth; i++) begin
      if (pend_valid[i] && pend_key[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int pending_total();
    int n;
    n = 0;
    foreach (pend_valid[i]) if (pend_valid[i]) n++;
    return n;
  endfunction

  function automatic void write_model_reg(logic [ctweb_pkg::CfgIdxW-1:0] idx,
                                          logic [31:0] data);
    case (idx)
      ctweb_pkg::RegSession: begin
        cur_session = data;
        empty_stores();
      end
      ctweb_pkg::RegGeneration: begin
        cur_generation = data;
        empty_stores();
      end
      ctweb_pkg::RegMaxPending: begin
        pend_limit = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
      end
      default: ;
    endcase
  endfunction

  // next state of the mirror and the result that one word causes
  function automatic outcome_t tracker_outcome(request_t r);
    outcome_t o;
    ctweb_pkg::early_ent_t ent;
    bit current;
    int hit;
    int slot;
    int n;
    o.action = ctweb_pkg::ActRejected;
    o.status = '0;
    o.diag   = '0;
    current = (r.session == cur_session) && (r.generation == cur_generation);
    case (r.command)
      ctweb_pkg::CmdTrack: begin
        if (current && r.present_id != '0 && find_pending(r.present_id) < 0) begin
          hit = -1;
          for (int i = 0; i < early_store.size(); i++) begin
            if (hit < 0 && early_store[i].key == r.present_id) hit = i;
          end
          if (hit >= 0) begin
            // oldest early completion is consumed, younger ones keep order
            o.action = early_store[hit].fail ? ctweb_pkg::ActConsumedFail :
                                               ctweb_pkg::ActConsumedOk;
            o.status = early_store[hit].status;
            o.diag   = early_store[hit].diag;
            early_store.delete(hit);
          end else begin
            n = pending_total();
            if (n < pend_limit && n < PendDepth) begin
              slot = -1;
              for (int i = 0; i < PendDepth; i++) begin
                if (slot < 0 && !pend_valid[i]) slot = i;
              end
              pend_valid[slot] = 1'b1;
              pend_key[slot]   = r.present_id;
              o.action = ctweb_pkg::ActPending;
            end
          end
        end
      end
      ctweb_pkg::CmdComplete: begin
        if (!current) begin
          o.action = ctweb_pkg::ActStale;
        end else begin
          slot = find_pending(r.present_id);
          if (slot >= 0) begin
            pend_valid[slot] = 1'b0;
            o.action = r.status_failed ? ctweb_pkg::ActAcceptedFail :
                                         ctweb_pkg::ActAcceptedOk;
          end else begin
            // park early completion, oldest drops out when full
            if (r.present_id != '0) begin
              if (early_store.size() >= EarlyDepth) early_store.delete(0);
              ent.key    = r.present_id;
              ent.status = r.status_code;
              ent.fail   = r.status_failed;
              ent.diag   = r.diag_tag;
              early_store.insert(early_store.size(), ent);
            end
            o.action = ctweb_pkg::ActUnknown;
          end
        end
      end
      ctweb_pkg::CmdClear: begin
        empty_stores();
        o.action = ctweb_pkg::ActCleared;
      end
      default: ;
    endcase
    o.count = ctweb_pkg::CountW'(pending_total());
    return o;
  endfunction

  function automatic request_t make_req(logic [1:0] cmd, logic [31:0] sess, logic [31:0] gen,
                                        logic [31:0] id, logic [7:0] st, logic fl,
                                        logic [31:0] dg);
    request_t r;
    r.command       = cmd;
    r.session       = sess;
    r.generation    = gen;
    r.present_id    = id;
    r.status_code   = st;
    r.status_failed = fl;
    r.diag_tag      = dg;
    return r;
  endfunction

  // mostly current words on a small id pool so tracks and completions meet
  function automatic request_t random_request(logic [31:0] id_base);
    request_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 46) r.command = ctweb_pkg::CmdTrack;
    else if (pick < 92) r.command = ctweb_pkg::CmdComplete;
    else if (pick < 96) r.command = ctweb_pkg::CmdClear;
    else r.command = CmdUnused;
    r.session    = cur_session;
    r.generation = cur_generation;
    pick = $urandom_range(0, 99);
    if (pick < 4) r.session = $urandom();
    else if (pick < 8) r.generation = $urandom();
    else if (pick < 10) r.session = cur_session ^ (32'h1 << $urandom_range(0, 31));
    else if (pick < 12) r.generation = cur_generation ^ (32'h1 << $urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 4) r.present_id = '0;
    else if (pick < 12) r.present_id = $urandom();
    else r.present_id = id_base + $urandom_range(1, 10);
    r.status_code   = 8'($urandom_range(0, 255));
    r.status_failed = 1'($urandom_range(0, 1));
    r.diag_tag      = $urandom();
    return r;
  endfunction

  task automatic queue_req(request_t r);
    request_backlog.insert(request_backlog.size(), r);
    words_queued++;
  endtask

  task automatic write_reg(logic [ctweb_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_accepted);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every queued word has its result back
  task automatic settle();
    wait (results_seen >= words_queued);
    repeat (4) @(negedge clk_i);
  endtask

  // sender: one word per handshake, random gap after each
  always @(negedge clk_i) begin
    request_t r;
    if (rst_ni && (!in_valid_i || in_accepted)) begin
      if (send_wait != 0) begin
        in_valid_i <= 1'b0;
        send_wait  <= send_wait - 1;
      end else if (request_backlog.size() != 0) begin
        r = request_backlog[0];
        request_backlog.delete(0);
        command_i       <= r.command;
        session_id_i    <= r.session;
        generation_i    <= r.generation;
        present_id_i    <= r.present_id;
        status_code_i   <= r.status_code;
        status_failed_i <= r.status_failed;
        diag_tag_i      <= r.diag_tag;
        in_valid_i      <= 1'b1;
        send_wait       <= draw_wait(send_quiet);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stall per word plus long hold-off on request
  always @(negedge clk_i) begin
    int unsigned w;
    if (rst_ni) begin
      w = out_accepted ? draw_wait(recv_quiet) : recv_wait;
      if (stall_seen != stall_asks) begin
        stall_seen  <= stall_asks;
        stall_left  <= HoldOffCycles;
        out_ready_i <= 1'b0;
        recv_wait   <= w;
      end else if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
        recv_wait   <= w;
      end else if (w != 0) begin
        out_ready_i <= 1'b0;
        recv_wait   <= w - 1;
      end else begin
        out_ready_i <= 1'b1;
        recv_wait   <= 0;
      end
    end
  end

  // monitor: predict on input words, check output words
  always @(posedge clk_i) begin
    request_t r;
    outcome_t want;
    if (!rst_ni) begin
      in_accepted  <= 1'b0;
      out_accepted <= 1'b0;
      cfg_accepted <= 1'b0;
    end else begin
      in_accepted  <= in_valid_i && in_ready_o;
      out_accepted <= out_valid_o && out_ready_i;
      cfg_accepted <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) write_model_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        r = make_req(command_i, session_id_i, generation_i, present_id_i, status_code_i,
                     status_failed_i, diag_tag_i);
        want = tracker_outcome(r);
        outcomes_due.insert(outcomes_due.size(), want);
      end
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (outcomes_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, action %0d", action_o));
        end else begin
          want = outcomes_due[0];
          outcomes_due.delete(0);
          if (action_o !== want.action)
            report_mismatch($sformatf("action got %0d want %0d", action_o, want.action));
          if (completion_status_o !== want.status)
            report_mismatch($sformatf("completion_status got %0h want %0h",
                                      completion_status_o, want.status));
          if (diag_out_o !== want.diag)
            report_mismatch($sformatf("diag_out got %0h want %0h", diag_out_o, want.diag));
          if (pending_count_o !== want.count)
            report_mismatch($sformatf("pending_count got %0d want %0d",
                                      pending_count_o, want.count));
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] id_base;
    logic [31:0] s;
    logic [31:0] g;
    // mirror at reset
    cur_session    = '0;
    cur_generation = '0;
    pend_limit     = ctweb_pkg::MaxPendReset;
    empty_stores();
    words_queued = 0;
    results_seen = 0;
    mismatches   = 0;
    send_quiet   = 1'b0;
    recv_quiet   = 1'b0;
    send_wait    = 0;
    recv_wait    = 0;
    stall_asks   = 0;
    stall_seen   = 0;
    stall_left   = 0;
    // every input known from the start
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = ctweb_pkg::RegSession;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    command_i       = ctweb_pkg::CmdTrack;
    session_id_i    = '0;
    generation_i    = '0;
    present_id_i    = '0;
    status_code_i   = '0;
    status_failed_i = 1'b0;
    diag_tag_i      = '0;
    out_ready_i     = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words at reset settings, session and generation zero
    queue_req(make_req(ctweb_pkg::CmdTrack, 0, 0, 32'd0, 8'h00, 1'b0, 32'h0));  // zero id
    queue_req(make_req(ctweb_pkg::CmdTrack, 0, 0, 32'd5, 8'h00, 1'b0, 32'h0));  // pending
    queue_req(make_req(ctweb_pkg::CmdTrack, 0, 0, 32'd5, 8'h00, 1'b0, 32'h0));  // duplicate
    queue_req(make_req(ctweb_pkg::CmdTrack, 32'hFFFF_FFFF, 0, 32'd9, 8'h00, 1'b0,
                       32'h0));                                            // stale session
    queue_req(make_req(ctweb_pkg::CmdTrack, 0, 32'hFFFF_FFFF, 32'd9, 8'h00, 1'b0,
                       32'h0));                                            // stale generation
    queue_req(make_req(ctweb_pkg::CmdComplete, 32'h1, 0, 32'd5, 8'hFF, 1'b1,
                       32'hFFFF_FFFF));                                    // stale
    queue_req(make_req(ctweb_pkg::CmdComplete, 0, 0, 32'd5, 8'hFF, 1'b0,
                       32'hFFFF_FFFF));                                    // accepted ok
    queue_req(make_req(ctweb_pkg::CmdTrack, 0, 0, 32'd6, 8'h00, 1'b0, 32'h0));
    queue_req(make_req(ctweb_pkg::CmdComplete, 0, 0, 32'd6, 8'h00, 1'b1,
                       32'h0));                                            // accepted fail
    queue_req(make_req(ctweb_pkg::CmdComplete, 0, 0, 32'd0, 8'h33, 1'b0,
                       32'h1));                                            // unknown, not kept
    queue_req(make_req(ctweb_pkg::CmdComplete, 0, 0, 32'hFFFF_FFFF, 8'hA5, 1'b1,
                       32'hFFFF_FFFF));
    queue_req(make_req(ctweb_pkg::CmdComplete, 0, 0, 32'd7, 8'h5A, 1'b0, 32'h1234_5678));
    queue_req(make_req(ctweb_pkg::CmdComplete, 0, 0, 32'd7, 8'h01, 1'b1, 32'h0));
    queue_req(make_req(ctweb_pkg::CmdTrack, 0, 0, 32'd7, 8'h00, 1'b0, 32'h0));  // oldest of two
    queue_req(make_req(ctweb_pkg::CmdTrack, 0, 0, 32'hFFFF_FFFF, 8'h00, 1'b0,
                       32'h0));                                            // consumed fail
    queue_req(make_req(ctweb_pkg::CmdTrack, 0, 0, 32'd7, 8'h00, 1'b0, 32'h0));  // younger one
    queue_req(make_req(CmdUnused, 0, 0, 32'd8, 8'h00, 1'b0, 32'h0));            // ignored command
    // overflow of the early store drops the oldest
    for (int i = 0; i < EarlyDepth + 1; i++)
      queue_req(make_req(ctweb_pkg::CmdComplete, 0, 0, 32'd100 + i, 8'(i), 1'b0,
                         32'h100 + i));
    queue_req(make_req(ctweb_pkg::CmdTrack, 0, 0, 32'd100, 8'h00, 1'b0, 32'h0));
    queue_req(make_req(ctweb_pkg::CmdTrack, 0, 0, 32'd101, 8'h00, 1'b0, 32'h0));
    queue_req(make_req(ctweb_pkg::CmdClear, 0, 0, 32'd0, 8'h00, 1'b0, 32'h0));
    queue_req(make_req(ctweb_pkg::CmdTrack, 0, 0, 32'd102, 8'h00, 1'b0, 32'h0));
    settle();

    // an unused register index changes nothing
    write_reg(RegUnused, $urandom());

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          write_reg(ctweb_pkg::RegSession, 32'hFFFF_FFFF);
          write_reg(ctweb_pkg::RegGeneration, 32'hFFFF_FFFF);
          write_reg(ctweb_pkg::RegMaxPending, 32'hFFFF_FFE0);   // zero becomes one
        end
        1: begin
          write_reg(ctweb_pkg::RegSession, 32'h0);
          write_reg(ctweb_pkg::RegGeneration, $urandom());
          write_reg(ctweb_pkg::RegMaxPending, 32'd31);          // above the depth
        end
        2: begin
          write_reg(ctweb_pkg::RegSession, $urandom());
          write_reg(ctweb_pkg::RegGeneration, 32'h0);
          write_reg(ctweb_pkg::RegMaxPending, 32'd16);
        end
        default: begin
          s = $urandom();
          g = $urandom();
          write_reg(ctweb_pkg::RegSession, s);
          write_reg(ctweb_pkg::RegGeneration, g);
          write_reg(ctweb_pkg::RegMaxPending, $urandom());
        end
      endcase
      id_base    = $urandom();
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        // single slot: second track finds the set full
        queue_req(make_req(ctweb_pkg::CmdTrack, cur_session, cur_generation, id_base + 1,
                           8'h0, 1'b0, 0));
        queue_req(make_req(ctweb_pkg::CmdTrack, cur_session, cur_generation, id_base + 2,
                           8'h0, 1'b0, 0));
      end
      if (p == 2) begin
        // receiver holds off while the sender keeps pushing
        send_quiet = 1'b1;
        stall_asks++;
      end
      repeat (PhaseWords) queue_req(random_request(id_base));
      settle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (outcomes_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ctweb_pkg.sv
rtl/completion_tracker_with_early_buffer.sv
rtl/ctweb_checker.sv
tb/completion_tracker_with_early_buffer_tb.sv
